@@ hdl/chte_pkg.sv @@
package chte_pkg;

   localparam logic [63:0] MIX_MULT = 64'hff51afd7ed558ccd;
   localparam int MIX_SHIFT = 33;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_INVALID     = 3'd1,
      ST_FULL        = 3'd2,
      ST_DUP         = 3'd3,
      ST_MISSING     = 3'd4,
      ST_BUCKET_FULL = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]   req_type;
      logic [63:0]  key;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [2:0]   status;
      logic signed [31:0] value_out;
      logic [9:0]   entry_count;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic        key_zero;
      logic [63:0] key;
      logic [31:0] value;
      logic [11:0] bucket;
   } work_type;

endpackage

@@ hdl/chte_ram.sv @@
module chte_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/chte_front.sv @@
module chte_front #(
   parameter int NUM_BUCKETS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  chte_pkg::req_type   in_item,
   output logic                out_valid,
   input  logic                out_take,
   output chte_pkg::work_type  out_work
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   // stage 1: pre-xor and low multiply halves; stage 2: combine, final xor
   logic               s1_valid_ff, s1_valid_in;
   chte_pkg::req_type  s1_item_ff;
   logic [63:0]        s1_ll_ff, s1_lh_ff, s1_hl_ff;
   logic               s2_valid_ff, s2_valid_in;
   chte_pkg::work_type s2_work_ff, s2_work_in;
   logic [63:0]        x_in;
   logic [63:0]        h;
   logic               s2_free;
   logic               s1_free;

   assign x_in = in_item.key ^ (in_item.key >> chte_pkg::MIX_SHIFT);
   assign s2_free = !s2_valid_ff || out_take;
   assign s1_free = !s1_valid_ff || s2_free;
   assign in_stall = !s1_free;
   assign s1_valid_in = s1_free ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      h = s1_ll_ff + ((s1_lh_ff + s1_hl_ff) << 32);
      h = h ^ (h >> chte_pkg::MIX_SHIFT);
      s2_work_in.kind = s1_item_ff.req_type;
      s2_work_in.key_zero = (s1_item_ff.key == 64'd0);
      s2_work_in.key = s1_item_ff.key;
      s2_work_in.value = s1_item_ff.value_in;
      s2_work_in.bucket = 12'(h[BW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_free && in_valid) begin
         s1_item_ff <= in_item;
         s1_ll_ff   <= 64'(x_in[31:0]) * 64'(chte_pkg::MIX_MULT[31:0]);
         s1_lh_ff   <= 64'(x_in[31:0]) * 64'(chte_pkg::MIX_MULT[63:32]);
         s1_hl_ff   <= 64'(x_in[63:32]) * 64'(chte_pkg::MIX_MULT[31:0]);
      end
      if (s2_free && s1_valid_ff) begin
         s2_work_ff <= s2_work_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_work = s2_work_ff;

`ifndef NO_ASSERTIONS
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_work_ff.key_zero == (s2_work_ff.key == 64'd0)))
      else $error("key zero flag wrong");
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_work_ff.bucket < 12'(NUM_BUCKETS)))
      else $error("bucket out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_take) |=> (s2_valid_ff && $stable(s2_work_ff)))
      else $error("front item lost");
`endif

endmodule

@@ hdl/chte_queue.sv @@
module chte_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_take,
   input  chte_pkg::work_type in_work,
   output logic               out_valid,
   input  logic               out_take,
   output chte_pkg::work_type out_work
);

   chte_pkg::work_type buf_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_take = (cnt_ff != 2'd2);
   assign push = in_valid && in_take;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop = out_valid && out_take;
   assign out_work = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) buf_ff[wp_ff] <= in_work;
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue push lost");
`endif

endmodule

@@ hdl/chte_back.sv @@
module chte_back #(
   parameter int NUM_BUCKETS  = 64,
   parameter int BUCKET_DEPTH = 8,
   parameter int MAX_DEFS     = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_take,
   input  chte_pkg::work_type in_work,
   input  logic [9:0]         max_entries,
   output logic               out_valid,
   input  logic               out_stall,
   output chte_pkg::rsp_type  out_item,
   output logic               busy
);

   localparam int NSLOT = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int AW = $clog2(NSLOT) > 0 ? $clog2(NSLOT) : 1;
   localparam int BW = $clog2(NUM_BUCKETS) > 0 ? $clog2(NUM_BUCKETS) : 1;
   localparam int DW = $clog2(BUCKET_DEPTH + 1);
   localparam int TW = $clog2(NSLOT + 1) > 10 ? $clog2(NSLOT + 1) : 10;
   localparam bit CAP_ON = (MAX_DEFS <= NSLOT);
   localparam int CAPV = CAP_ON ? MAX_DEFS : 0;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_FILL  = 8'b00000100,
      S_READ  = 8'b00001000,
      S_SCAN  = 8'b00010000,
      S_SHIFT = 8'b00100000,
      S_WAIT  = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [TW-1:0] total_ff, total_in;
   chte_pkg::work_type w_ff, w_in;
   logic [DW-1:0] idx_ff, idx_in;
   logic [DW-1:0] n_ff, n_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   vo_ff, vo_in;
   logic          ov_ff, ov_in;
   chte_pkg::rsp_type ri_ff, ri_in;

   logic          kwe, vwe;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   kwd, krd;
   logic [31:0]   vwd, vrd;
   logic          fill_we;
   logic [BW-1:0] fill_waddr, fill_raddr;
   logic [DW-1:0] fill_wd, fill_rd;
   logic [AW-1:0] base;
   logic          out_free;

   chte_ram #(.WIDTH(64), .DEPTH(NSLOT)) u_keys (
      .clock(clock), .wr_en(kwe), .wr_addr(waddr), .wr_data(kwd),
      .rd_addr(raddr), .rd_data(krd));
   chte_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_vals (
      .clock(clock), .wr_en(vwe), .wr_addr(waddr), .wr_data(vwd),
      .rd_addr(raddr), .rd_data(vrd));
   chte_ram #(.WIDTH(DW), .DEPTH(NUM_BUCKETS)) u_fill (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_waddr), .wr_data(fill_wd),
      .rd_addr(fill_raddr), .rd_data(fill_rd));

   assign base = AW'(w_ff.bucket[BW-1:0] * BUCKET_DEPTH);
   assign out_free = !ov_ff || !out_stall;
   assign in_take = (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE) || ov_ff;
   assign fill_raddr = in_work.bucket[BW-1:0];

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      total_in = total_ff;
      w_in = w_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      st_in = st_ff;
      vo_in = vo_ff;
      ov_in = ov_ff && out_stall;
      ri_in = ri_ff;
      kwe = 1'b0;
      vwe = 1'b0;
      waddr = base + AW'(idx_ff);
      kwd = w_ff.key;
      vwd = w_ff.value;
      raddr = base + AW'(idx_ff);
      fill_we = 1'b0;
      fill_waddr = w_ff.bucket[BW-1:0];
      fill_wd = n_ff;
      case (state_ff)
         S_CLEAR: begin
            fill_we = 1'b1;
            fill_waddr = clr_ff;
            fill_wd = '0;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(NUM_BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid) begin
               w_in = in_work;
               idx_in = '0;
               vo_in = '0;
               st_in = chte_pkg::ST_MISSING;
               state_in = S_DONE;
               if (in_work.kind == chte_pkg::REQ_NONE) begin
                  st_in = chte_pkg::ST_MISSING;
               end else if (in_work.key_zero) begin
                  st_in = chte_pkg::ST_INVALID;
               end else if (in_work.kind == chte_pkg::REQ_INSERT &&
                            (total_ff >= TW'(max_entries) ||
                             (CAP_ON && total_ff >= TW'(CAPV)))) begin
                  st_in = chte_pkg::ST_FULL;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            n_in = fill_rd;
            state_in = S_READ;
         end
         S_READ: begin
            // issue read of slot idx
            if (idx_ff >= n_ff) begin
               if (w_ff.kind == chte_pkg::REQ_INSERT) begin
                  if (n_ff >= DW'(BUCKET_DEPTH)) begin
                     st_in = chte_pkg::ST_BUCKET_FULL;
                  end else begin
                     kwe = 1'b1;
                     vwe = 1'b1;
                     fill_we = 1'b1;
                     fill_wd = n_ff + DW'(1);
                     total_in = total_ff + TW'(1);
                     st_in = chte_pkg::ST_OK;
                  end
               end
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (krd == w_ff.key) begin
               case (w_ff.kind)
                  chte_pkg::REQ_INSERT: begin
                     st_in = chte_pkg::ST_DUP;
                     state_in = S_DONE;
                  end
                  chte_pkg::REQ_LOOKUP: begin
                     st_in = chte_pkg::ST_OK;
                     vo_in = vrd;
                     state_in = S_DONE;
                  end
                  default: begin
                     st_in = chte_pkg::ST_OK;
                     fill_we = 1'b1;
                     fill_wd = n_ff - DW'(1);
                     if (total_ff != '0) total_in = total_ff - TW'(1);
                     idx_in = idx_ff + DW'(1);
                     state_in = S_SHIFT;
                  end
               endcase
            end else begin
               idx_in = idx_ff + DW'(1);
               state_in = S_READ;
            end
         end
         S_SHIFT: begin
            // idx points at the slot to move down; read it
            if (idx_ff >= n_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            kwe = 1'b1;
            vwe = 1'b1;
            waddr = base + AW'(idx_ff) - AW'(1);
            kwd = krd;
            vwd = vrd;
            idx_in = idx_ff + DW'(1);
            state_in = S_SHIFT;
         end
         S_DONE: begin
            if (out_free) begin
               ov_in = 1'b1;
               ri_in.status = st_ff;
               ri_in.value_out = vo_ff;
               ri_in.entry_count = total_ff[9:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         ov_ff <= ov_in;
      end
      w_ff <= w_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      st_ff <= st_in;
      vo_ff <= vo_in;
      ri_ff <= ri_in;
   end

   assign out_valid = ov_ff;
   assign out_item = ri_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(NSLOT))
      else $error("total out of range");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wd <= DW'(BUCKET_DEPTH)))
      else $error("bucket fill overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && out_stall) |=> (ov_ff && $stable(ri_ff)))
      else $error("result dropped");
`endif

endmodule

@@ hdl/chained_hash_table_engine_core.sv @@
// Hash table of 64-bit keys with 32-bit values in NUM_BUCKETS buckets (a power of two) of
// BUCKET_DEPTH slots, held in RAMs. A two-stage front pipe (split 64-bit multiply) mixes
// the key into a bucket index and feeds a two-entry queue; the back sequencer then handles
// one item at a time. In the back, an item that scans the bucket reads and compares one
// occupied slot at a time, and a remove then compacts the slots behind the hit. Early
// refusals skip the scan. After reset a clear pass zeroes the fill counts while the back
// takes no items. Write max_entries only when the block is idle.
module chained_hash_table_engine_core #(
   parameter int NUM_BUCKETS  = 64,
   parameter int BUCKET_DEPTH = 8,
   parameter int MAX_DEFS     = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  chte_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chte_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [9:0]        csr_data
);

   logic               f_valid, f_take;
   chte_pkg::work_type f_work;
   logic               q_valid, q_take;
   chte_pkg::work_type q_work;
   logic               busy;
   logic [9:0]         max_entries_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= 10'd512;
      end else if (csr_valid && csr_ready) begin
         max_entries_ff <= csr_data;
      end
   end

   chte_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_item(req_item),
      .out_valid(f_valid), .out_take(f_take), .out_work(f_work));

   chte_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_take(f_take), .in_work(f_work),
      .out_valid(q_valid), .out_take(q_take), .out_work(q_work));

   chte_back #(
      .NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .MAX_DEFS(MAX_DEFS)
   ) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_take(q_take), .in_work(q_work),
      .max_entries(max_entries_ff),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_item(rsp_item),
      .busy(busy));

`ifndef NO_ASSERTIONS
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && busy) |-> !q_valid || busy)
      else $error("config during activity");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("response changed while stalled");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.entry_count <= 10'(MAX_DEFS > 1023 ? 1023 : MAX_DEFS)))
      else $error("entry count too high");
`endif

endmodule

@@ dv/chained_hash_table_engine_core_tb.sv @@
module chained_hash_table_engine_core_tb;

   localparam int N_BUCKETS  = 64;
   localparam int SLOTS      = 8;
   localparam int TABLE_CAP  = 512;
   localparam int CYCLE_CAP  = 400000;
   localparam int SETTLE     = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   chte_pkg::req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   chte_pkg::rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [9:0] csr_data = '0;

   chained_hash_table_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table shadow
   logic [63:0] shadow_keys [N_BUCKETS][SLOTS];
   logic [31:0] shadow_vals [N_BUCKETS][SLOTS];
   int          shadow_fill [N_BUCKETS];
   int          shadow_total;
   int          entry_limit;

   chte_pkg::rsp_type pending_rsps[$];
   int          err_count;
   bit          gaps_on;
   int          hold_left;
   int          stall_left;
   int          cycle_count;
   logic [63:0] key_pool[48];

   function automatic logic [5:0] bucket_of(logic [63:0] k);
      logic [63:0] h;
      h = k ^ (k >> chte_pkg::MIX_SHIFT);
      h = h * chte_pkg::MIX_MULT;
      h = h ^ (h >> chte_pkg::MIX_SHIFT);
      return h[5:0];
   endfunction

   function automatic int slot_of(logic [5:0] b, logic [63:0] k);
      for (int i = 0; i < shadow_fill[b]; i++)
         if (shadow_keys[b][i] == k) return i;
      return -1;
   endfunction

   function automatic chte_pkg::rsp_type apply_request(chte_pkg::req_type r);
      chte_pkg::rsp_type o;
      logic [5:0]  b;
      int          pos;
      o = '0;
      o.status = chte_pkg::ST_MISSING;
      b = bucket_of(r.key);
      if (r.req_type != chte_pkg::REQ_NONE) begin
         if (r.key == 0) begin
            o.status = chte_pkg::ST_INVALID;
         end else if (r.req_type == chte_pkg::REQ_INSERT) begin
            if (shadow_total >= entry_limit || shadow_total >= TABLE_CAP)
               o.status = chte_pkg::ST_FULL;
            else if (slot_of(b, r.key) >= 0)
               o.status = chte_pkg::ST_DUP;
            else if (shadow_fill[b] >= SLOTS)
               o.status = chte_pkg::ST_BUCKET_FULL;
            else begin
               shadow_keys[b][shadow_fill[b]] = r.key;
               shadow_vals[b][shadow_fill[b]] = r.value_in;
               shadow_fill[b]++;
               shadow_total++;
               o.status = chte_pkg::ST_OK;
            end
         end else begin
            pos = slot_of(b, r.key);
            if (pos >= 0) begin
               o.status = chte_pkg::ST_OK;
               if (r.req_type == chte_pkg::REQ_LOOKUP) begin
                  o.value_out = shadow_vals[b][pos];
               end else begin
                  for (int i = pos; i + 1 < shadow_fill[b]; i++) begin
                     shadow_keys[b][i] = shadow_keys[b][i + 1];
                     shadow_vals[b][i] = shadow_vals[b][i + 1];
                  end
                  shadow_fill[b]--;
                  shadow_total--;
               end
            end
         end
      end
      o.entry_count = shadow_total[9:0];
      return o;
   endfunction

   task automatic send_item(chte_pkg::req_kind_type t, logic [63:0] k, logic [31:0] v);
      chte_pkg::req_type r;
      r.req_type = t;
      r.key = k;
      r.value_in = v;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(apply_request(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(logic [9:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      entry_limit = v;
   endtask

   function automatic logic [63:0] key_in_bucket(logic [5:0] b);
      logic [63:0] k;
      do k = {$urandom, $urandom}; while (bucket_of(k) != b || k == 0);
      return k;
   endfunction

   function automatic chte_pkg::req_kind_type pick_kind();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return chte_pkg::REQ_INSERT;
      if (p < 70) return chte_pkg::REQ_LOOKUP;
      if (p < 97) return chte_pkg::REQ_REMOVE;
      return chte_pkg::REQ_NONE;
   endfunction

   task automatic test_basic_ops();
      send_item(chte_pkg::REQ_INSERT, 64'd1, 32'h7fffffff);
      send_item(chte_pkg::REQ_INSERT, '1, 32'h80000000);
      send_item(chte_pkg::REQ_LOOKUP, 64'd1, 32'h0);
      send_item(chte_pkg::REQ_LOOKUP, '1, '1);
      send_item(chte_pkg::REQ_INSERT, 64'd1, 32'h1234);
      send_item(chte_pkg::REQ_INSERT, 64'd0, 32'h5);
      send_item(chte_pkg::REQ_LOOKUP, 64'd0, 32'h0);
      send_item(chte_pkg::REQ_REMOVE, 64'd0, 32'h0);
      send_item(chte_pkg::REQ_LOOKUP, 64'h8000000000000000, 32'h0);
      send_item(chte_pkg::REQ_REMOVE, 64'h8000000000000000, 32'h0);
      send_item(chte_pkg::REQ_NONE, '1, '1);
      send_item(chte_pkg::REQ_REMOVE, 64'd1, 32'h0);
      send_item(chte_pkg::REQ_LOOKUP, 64'd1, 32'h0);
      send_item(chte_pkg::REQ_REMOVE, '1, 32'h0);
   endtask

   task automatic test_bucket_chain();
      logic [63:0] ks[10];
      logic [5:0]  b;
      b = 6'($urandom);
      foreach (ks[i]) ks[i] = key_in_bucket(b);
      for (int i = 0; i < 9; i++) send_item(chte_pkg::REQ_INSERT, ks[i], $urandom);
      send_item(chte_pkg::REQ_REMOVE, ks[3], 32'h0);
      send_item(chte_pkg::REQ_REMOVE, ks[0], 32'h0);
      send_item(chte_pkg::REQ_INSERT, ks[9], $urandom);
      foreach (ks[i]) send_item(chte_pkg::REQ_LOOKUP, ks[i], 32'h0);
      send_item(chte_pkg::REQ_REMOVE, ks[7], 32'h0);
      foreach (ks[i]) send_item(chte_pkg::REQ_REMOVE, ks[i], 32'h0);
   endtask

   task automatic test_entry_limit();
      write_limit(10'd0);
      send_item(chte_pkg::REQ_INSERT, 64'h55, 32'h1);
      send_item(chte_pkg::REQ_INSERT, 64'h0, 32'h1);
      write_limit(10'd3);
      for (int i = 1; i <= 5; i++)
         send_item(chte_pkg::REQ_INSERT, 64'h100 + 64'(i), 32'(i));
      send_item(chte_pkg::REQ_REMOVE, 64'h101, 32'h0);
      send_item(chte_pkg::REQ_INSERT, 64'h105, 32'h5);
      write_limit(10'h3ff);
      for (int i = 1; i <= 5; i++)
         send_item(chte_pkg::REQ_REMOVE, 64'h100 + 64'(i), 32'h0);
   endtask

   task automatic test_random(int n);
      logic [63:0] k;
      int          p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 4) k = '0;
         else if (p < 80) k = key_pool[$urandom_range(0, 47)];
         else k = {$urandom, $urandom};
         send_item(pick_kind(), k, $urandom);
      end
   endtask

   task automatic test_backpressure();
      hold_left = 300;
      for (int i = 0; i < 20; i++)
         send_item(pick_kind(), key_pool[$urandom_range(0, 47)], $urandom);
      wait_idle();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("chained_hash_table_engine_core_tb: done, errors");
         $finish;
      end
   end

   // receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (gaps_on && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      chte_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $error("unexpected result %p", rsp_item);
               err_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  err_count++;
               end
               if (rsp_item.value_out !== want.value_out) begin
                  $error("value_out: expected %0d, actual %0d",
                         want.value_out, rsp_item.value_out);
                  err_count++;
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_item.entry_count);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      err_count = 0;
      hold_left = 0;
      stall_left = 0;
      gaps_on = 1'b1;
      shadow_total = 0;
      entry_limit = 512;
      foreach (shadow_fill[i]) shadow_fill[i] = 0;
      for (int i = 0; i < 48; i++)
         key_pool[i] = (i < 24) ? key_in_bucket(6'(i % 3)) : {$urandom, $urandom};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_bucket_chain();
      test_entry_limit();
      write_limit(10'd512);
      test_random(200);
      test_backpressure();
      write_limit(10'd40);
      test_random(120);
      wait_idle();
      write_limit(10'd512);
      test_random(100);
      gaps_on = 1'b0;
      test_random(60);
      wait_idle();
      if (err_count == 0)
         $display("chained_hash_table_engine_core_tb: done, clean");
      else
         $display("chained_hash_table_engine_core_tb: done, errors");
      $finish;
   end
endmodule
